// ===== sv/cht_pkg.sv =====
// Package with the command and status codes and the controller state type of the hash table.
package cht_pkg;
   localparam int CMD_W = 2;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIND   = 2'd1,
      CMD_ERASE  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_MOD,
      S_HEAD,
      S_WALK,
      S_FIX,
      S_DONE
   } state_type;
endpackage

// ===== sv/cht_mod.sv =====
// Sequential unit that reduces a signed key to a non-negative bucket index.
module cht_mod #(
   parameter int BUCKETS = 11,
   parameter int BKT_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            key,
   output logic                   done,
   output logic [BKT_W-1:0]       bucket
);
   import cht_pkg::*;

   // Residues of the byte weights 2^0, 2^8, 2^16 and 2^24, and of -2^32, which is
   // what the sign bit adds to the unsigned reading of the key.
   localparam logic [11:0] W0 = 12'(1 % BUCKETS);
   localparam logic [11:0] W1 = 12'(256 % BUCKETS);
   localparam logic [11:0] W2 = 12'(65536 % BUCKETS);
   localparam logic [11:0] W3 = 12'(64'd16777216 % BUCKETS);
   localparam logic [11:0] WN = 12'((BUCKETS - 64'd4294967296 % BUCKETS) % BUCKETS);
   // Scaled reciprocal; the quotient estimate is at most one below the true one.
   localparam logic [22:0] RECIP = 23'(64'd4194304 / BUCKETS);
   localparam logic [21:0] BK = 22'(BUCKETS);

   logic [21:0] fold_ff, fold_in;
   logic [21:0] quo_ff, quo_in;
   logic [21:0] rem_ff, rem_in;
   logic [2:0]  vld_ff, vld_in;
   logic [43:0] prod;
   logic [21:0] diff;

   // Stage one folds the key into a value below 2^22 with the same residue,
   // stage two estimates the quotient, stage three subtracts and corrects.
   always_comb begin
      fold_in = 22'(key[7:0]) * 22'(W0) + 22'(key[15:8]) * 22'(W1)
              + 22'(key[23:16]) * 22'(W2) + 22'(key[31:24]) * 22'(W3)
              + (key[31] ? 22'(WN) : 22'd0);
      prod = 44'(fold_ff) * 44'(RECIP);
      quo_in = prod[43:22];
      diff = fold_ff - quo_ff * BK;
      rem_in = (diff >= BK) ? diff - BK : diff;
      vld_in = {vld_ff[1:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (start) fold_ff <= fold_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = vld_ff[2];
   assign bucket = rem_ff[BKT_W-1:0];
endmodule

// ===== sv/cht_node_mem.sv =====
// Node pool memory holding key, value and link of every node.
module cht_node_mem #(
   parameter int NODES = 256,
   parameter int IDX_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-2:0]  wr_addr,
   input  logic              wr_kv,
   input  logic [31:0]       wr_key,
   input  logic [31:0]       wr_val,
   input  logic [IDX_W-1:0]  wr_link,
   input  logic [IDX_W-2:0]  rd_addr,
   output logic [31:0]       rd_key,
   output logic [31:0]       rd_val,
   output logic [IDX_W-1:0]  rd_link
);
   import cht_pkg::*;

   logic [31:0]      key_mem [NODES];
   logic [31:0]      val_mem [NODES];
   logic [IDX_W-1:0] link_mem [NODES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_link;
         if (wr_kv) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
         end
      end
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
      rd_link <= link_mem[rd_addr];
   end
endmodule

// ===== sv/chained_hash_table_top.sv =====
// Top level of the chained hash table: controller, bucket heads and node pool.
// Each request is an insert, find or erase on a signed key. The bucket is the
// key modulo BUCKETS, found by a remainder unit that folds the key
// bytes with constant weights, multiplies by a reciprocal and corrects the remainder.
// An insert or an unused command passes the states MOD, HEAD and DONE; a find
// or erase on a non-empty bucket also passes WALK, where each visited node takes
// a read of the node memory and a compare, and an erase that matches adds the
// unlink state FIX. After reset a clearing pass writes the link of every node to
// build the free list in the link memory, and no request is accepted during it.
// One request is in work at a time; the response register holds a result while
// the next request is already taken, and that request waits in its DONE state
// until the register is free.
module chained_hash_table_top #(
   parameter int BUCKETS = 11,
   parameter int NODES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata fields from bit 0: cmd[1:0], key[33:2], payload[65:34], zero fill.
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata fields from bit 0: found[0], read_value[32:1], status[34:33], zero fill.
   output logic [39:0] rsp_tdata
);
   import cht_pkg::*;

   localparam int IDX_W = $clog2(NODES) + 1;
   localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [IDX_W-1:0] NIL = IDX_W'(NODES);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] bhead_ff [BUCKETS];
   logic [IDX_W-1:0] free_ff, free_in;
   logic [IDX_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [IDX_W-1:0] steps_ff, steps_in;
   cmd_type          cmd_ff;
   logic [31:0]      key_ff, pay_ff;
   logic [BKT_W-1:0] bkt_ff, bkt_in;
   logic             rv_ff, rv_in;
   logic             fnd_ff, fnd_in;
   logic [31:0]      val_ff, val_in;
   status_type       st_ff, st_in;
   logic             out_fnd_ff, out_fnd_in;
   logic [31:0]      out_val_ff, out_val_in;
   status_type       out_st_ff, out_st_in;
   logic             pend_ff, pend_in;
   logic             accept;
   logic             out_free;

   logic             mod_start, mod_done;
   logic [BKT_W-1:0] mod_bucket;

   logic             wr_en, wr_kv;
   logic [IDX_W-2:0] wr_addr, rd_addr;
   logic [IDX_W-1:0] wr_link, rd_link, rd_next;
   logic [31:0]      rd_key, rd_val;
   logic             head_we;
   logic [IDX_W-1:0] head_wd;
   logic [IDX_W-1:0] head_cur;

   cht_mod #(.BUCKETS(BUCKETS), .BKT_W(BKT_W)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .key(req_tdata[33:2]),
      .done(mod_done), .bucket(mod_bucket));

   cht_node_mem #(.NODES(NODES), .IDX_W(IDX_W)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_kv(wr_kv),
      .wr_key(key_ff), .wr_val(pay_ff), .wr_link(wr_link), .rd_addr(rd_addr),
      .rd_key(rd_key), .rd_val(rd_val), .rd_link(rd_link));

   // A link at or above NODES reads as null.
   assign rd_next = (rd_link >= NIL) ? NIL : rd_link;
   assign head_cur = (bhead_ff[bkt_ff] >= NIL) ? NIL : bhead_ff[bkt_ff];
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign mod_start = accept;
   // The response register can take a new result when it is empty or being read.
   assign out_free = !rv_ff || rsp_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {5'd0, out_st_ff, out_val_ff, out_fnd_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: if (cur_ff == NIL - IDX_W'(1)) state_in = S_IDLE;
         S_IDLE: if (accept) state_in = S_MOD;
         S_MOD:  if (mod_done) state_in = S_HEAD;
         S_HEAD: begin
            if (cmd_ff == CMD_INSERT || cmd_ff == CMD_NOP) state_in = S_DONE;
            else if (head_cur == NIL) state_in = S_DONE;
            else state_in = S_WALK;
         end
         S_WALK: begin
            if (pend_ff) state_in = S_WALK;
            else if (rd_key == key_ff)
               state_in = (cmd_ff == CMD_ERASE) ? S_FIX : S_DONE;
            else if (rd_next == NIL || steps_ff == NIL - IDX_W'(1)) state_in = S_DONE;
         end
         S_FIX:  state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      free_in = free_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      steps_in = steps_ff;
      bkt_in = bkt_ff;
      rv_in = rv_ff && !rsp_tready;
      fnd_in = fnd_ff;
      val_in = val_ff;
      st_in = st_ff;
      out_fnd_in = out_fnd_ff;
      out_val_in = out_val_ff;
      out_st_in = out_st_ff;
      pend_in = 1'b0;
      wr_en = 1'b0;
      wr_kv = 1'b0;
      wr_addr = cur_ff[IDX_W-2:0];
      wr_link = NIL;
      rd_addr = cur_ff[IDX_W-2:0];
      head_we = 1'b0;
      head_wd = NIL;
      unique case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            wr_link = cur_ff + IDX_W'(1);
            cur_in = cur_ff + IDX_W'(1);
         end
         S_IDLE: begin
            fnd_in = fnd_ff;
         end
         S_MOD: begin
            bkt_in = mod_bucket;
         end
         S_HEAD: begin
            fnd_in = 1'b0;
            val_in = '0;
            st_in = ST_OK;
            cur_in = head_cur;
            prev_in = NIL;
            steps_in = '0;
            pend_in = 1'b1;
            rd_addr = head_cur[IDX_W-2:0];
            if (cmd_ff == CMD_INSERT) begin
               if (free_ff >= NIL) st_in = ST_FULL;
               else begin
                  // Read the free node's link now; it lands next cycle.
                  rd_addr = free_ff[IDX_W-2:0];
                  cur_in = free_ff;
               end
            end else if (cmd_ff != CMD_NOP && head_cur == NIL) begin
               st_in = ST_NOT_FOUND;
            end
         end
         S_WALK: begin
            if (!pend_ff) begin
               if (rd_key == key_ff) begin
                  fnd_in = 1'b1;
                  if (cmd_ff == CMD_FIND) val_in = rd_val;
                  cur_in = rd_next;
                  steps_in = cur_ff;
               end else if (rd_next == NIL || steps_ff == NIL - IDX_W'(1)) begin
                  st_in = ST_NOT_FOUND;
               end else begin
                  prev_in = cur_ff;
                  cur_in = rd_next;
                  steps_in = steps_ff + IDX_W'(1);
                  rd_addr = rd_next[IDX_W-2:0];
                  pend_in = 1'b1;
               end
            end
         end
         S_FIX: begin
            // cur holds the successor, steps the erased node.
            if (prev_ff == NIL) begin
               head_we = 1'b1;
               head_wd = cur_ff;
            end else begin
               wr_en = 1'b1;
               wr_addr = prev_ff[IDX_W-2:0];
               wr_link = cur_ff;
            end
         end
         S_DONE: begin
            // The state is committed in the cycle the result moves to the
            // response register. While waiting, the read port keeps reading the
            // free node, so an insert still sees its link.
            if (out_free) begin
               rv_in = 1'b1;
               out_fnd_in = fnd_ff;
               out_val_in = val_ff;
               out_st_in = st_ff;
               if (cmd_ff == CMD_INSERT && st_ff == ST_OK) begin
                  wr_en = 1'b1;
                  wr_kv = 1'b1;
                  wr_addr = cur_ff[IDX_W-2:0];
                  wr_link = head_cur;
                  free_in = rd_next;
                  head_we = 1'b1;
                  head_wd = cur_ff;
               end else if (cmd_ff == CMD_ERASE && fnd_ff) begin
                  wr_en = 1'b1;
                  wr_addr = steps_ff[IDX_W-2:0];
                  wr_link = (free_ff >= NIL) ? NIL : free_ff;
                  free_in = steps_ff;
               end
            end
         end
         default: begin
            rv_in = rv_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cur_ff <= '0;
         free_ff <= '0;
         rv_ff <= 1'b0;
         pend_ff <= 1'b0;
         for (int i = 0; i < BUCKETS; i++) bhead_ff[i] <= NIL;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         free_ff <= free_in;
         rv_ff <= rv_in;
         pend_ff <= pend_in;
         if (head_we) bhead_ff[bkt_ff] <= head_wd;
      end
      prev_ff <= prev_in;
      steps_ff <= steps_in;
      bkt_ff <= bkt_in;
      fnd_ff <= fnd_in;
      val_ff <= val_in;
      st_ff <= st_in;
      out_fnd_ff <= out_fnd_in;
      out_val_ff <= out_val_in;
      out_st_ff <= out_st_in;
      if (accept) begin
         cmd_ff <= cmd_type'(req_tdata[1:0]);
         key_ff <= req_tdata[33:2];
         pay_ff <= req_tdata[65:34];
      end
   end

`ifndef SYNTHESIS
   // A response that is offered stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   // The reserved status code never appears in a response.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:33] != ST_RSVD)
      else $error("reserved status in response");
   // No response reports a value without a match.
   a_value_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("value without match");
`endif
endmodule

// ===== sim/cht_checker.sv =====
// Checker for the chained hash table: watches both channels, predicts and compares responses.
`timescale 1ns / 100ps
module cht_checker
   import cht_pkg::*;
#(
   parameter int BUCKETS = 11,
   parameter int NODES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          error_count,
   output int          pending_count
);
   typedef struct packed {
      logic                found;
      logic [VAL_W-1:0]    read_value;
      status_type          status;
   } reply_type;

   localparam int NIL = NODES;

   int               head_of[BUCKETS];
   logic [KEY_W-1:0] key_of[NODES];
   logic [VAL_W-1:0] value_of[NODES];
   int               next_of[NODES];
   int               free_top;
   reply_type        replies_due[$];

   function automatic int bucket_index(logic signed [KEY_W-1:0] k);
      longint r;
      r = longint'(k) % BUCKETS;
      if (r < 0) r += BUCKETS;
      return int'(r);
   endfunction

   // Applies one request to the shadow table and returns the reply it should give.
   function automatic reply_type hash_apply(cmd_type c, logic [KEY_W-1:0] k,
                                            logic [VAL_W-1:0] v);
      reply_type rr;
      int b, cur, prv, hit, steps;
      rr = '{1'b0, '0, ST_OK};
      b = bucket_index(k);
      if (c == CMD_INSERT) begin
         if (free_top >= NIL) begin
            rr.status = ST_FULL;
         end else begin
            cur = free_top;
            free_top = next_of[cur];
            key_of[cur] = k;
            value_of[cur] = v;
            next_of[cur] = head_of[b];
            head_of[b] = cur;
         end
      end else if (c == CMD_FIND || c == CMD_ERASE) begin
         cur = head_of[b];
         prv = NIL;
         hit = NIL;
         steps = 0;
         while (cur != NIL && steps < NODES && hit == NIL) begin
            if (key_of[cur] == k) hit = cur;
            else begin
               prv = cur;
               cur = next_of[cur];
            end
            steps++;
         end
         if (hit == NIL) begin
            rr.status = ST_NOT_FOUND;
         end else begin
            rr.found = 1'b1;
            if (c == CMD_FIND) begin
               rr.read_value = value_of[hit];
            end else begin
               if (prv == NIL) head_of[b] = next_of[hit];
               else next_of[prv] = next_of[hit];
               next_of[hit] = free_top;
               free_top = hit;
            end
         end
      end
      return rr;
   endfunction

   initial begin
      for (int i = 0; i < BUCKETS; i++) head_of[i] = NIL;
      for (int i = 0; i < NODES; i++) next_of[i] = i + 1;
      free_top = 0;
      error_count = 0;
   end

   assign pending_count = replies_due.size();

   always @(posedge clock) begin
      reply_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tdata[0];
            got.read_value = rsp_tdata[32:1];
            got.status = status_type'(rsp_tdata[34:33]);
            if (replies_due.size() == 0) begin
               $display("%0t: response with none expected: found %0b value %h status %0d",
                        $time, got.found, got.read_value, got.status);
               error_count++;
            end else begin
               want = replies_due.pop_front();
               if (got.found !== want.found) begin
                  $display("%0t: found mismatch: expected %0b, actual %0b",
                           $time, want.found, got.found);
                  error_count++;
               end
               if (got.read_value !== want.read_value) begin
                  $display("%0t: read_value mismatch: expected %h, actual %h",
                           $time, want.read_value, got.read_value);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, got.status);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            replies_due.push_back(hash_apply(cmd_type'(req_tdata[1:0]),
                                             req_tdata[33:2], req_tdata[65:34]));
      end
   end
endmodule

// ===== sim/tb_chained_hash_table_top.sv =====
// Testbench top for the chained hash table: stimulus, response stalls and the verdict.
`timescale 1ns / 100ps
module tb_chained_hash_table_top;
   import cht_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // Request fields from bit 0: cmd[1:0], key[33:2], payload[65:34], zero fill.
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // Response fields from bit 0: found[0], read_value[32:1], status[34:33], zero fill.
   logic [39:0] rsp_tdata;
   int          error_count;
   int          pending_count;

   // Keys reused by the random part so that finds and erases mostly hit live
   // entries and chains grow several nodes deep.
   logic [31:0] key_pool[$];
   // The receiver process holds off for a long stretch while this is set.
   bit          long_hold;

   chained_hash_table_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   cht_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sends one request and holds it until the block takes it. Valid stays high
   // from one request to the next; the caller lowers it during gaps.
   task automatic send_request(cmd_type c, logic [31:0] k, logic [31:0] v);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, v, k, c};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_responses;
      idle_cycles(1);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Picks a key: mostly from the reused set, sometimes a fresh random one or
   // one of the extreme values.
   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 75 && key_pool.size() != 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (sel < 80) return 32'h8000_0000;
      if (sel < 85) return 32'h7FFF_FFFF;
      return $urandom;
   endfunction

   // The receiver stalls in phases: always ready, random stalls, or mostly
   // stalled, plus a long hold-off on request.
   initial begin
      int mode;
      rsp_tready <= 1'b0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      cmd_type c;
      logic [31:0] k;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      long_hold = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extreme keys and payloads, every command, misses,
      // shadowed duplicates, erase of a head and of a middle node, and cmd 3.
      send_request(CMD_FIND, 32'h0, 32'h0);
      send_request(CMD_ERASE, 32'h0, 32'h0);
      send_request(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 32'hFFFF_FFF5, 32'h1);
      send_request(CMD_FIND, 32'h8000_0000, 32'h0);
      send_request(CMD_FIND, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_FIND, 32'hFFFF_FFFF, 32'h0);
      send_request(CMD_INSERT, 32'd22, 32'hAAAA_5555);
      send_request(CMD_INSERT, 32'd11, 32'h5555_AAAA);
      send_request(CMD_INSERT, 32'd22, 32'h1234_5678);
      send_request(CMD_FIND, 32'd22, 32'h0);
      send_request(CMD_ERASE, 32'd11, 32'h0);
      send_request(CMD_FIND, 32'd22, 32'h0);
      send_request(CMD_ERASE, 32'd22, 32'h0);
      send_request(CMD_FIND, 32'd22, 32'h0);
      send_request(CMD_ERASE, 32'd22, 32'h0);
      send_request(CMD_ERASE, 32'd22, 32'h0);
      send_request(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_FIND, 32'd33, 32'h0);
      drain_responses();

      // Fill the whole pool so that inserts are rejected as full, then empty it.
      // The long hold-off makes the block back up while requests keep coming.
      long_hold = 1'b1;
      for (int i = 0; i < 262; i++) begin
         k = (i < 180) ? $urandom_range(0, 40) : $urandom;
         key_pool.push_back(k);
         send_request(CMD_INSERT, k, $urandom);
      end
      for (int i = 0; i < 6; i++) send_request(CMD_FIND, key_pool[i], 32'h0);
      drain_responses();
      for (int i = 0; i < key_pool.size(); i++)
         send_request(CMD_ERASE, key_pool[i], $urandom);
      drain_responses();
      key_pool.delete();

      // Random part: bursts with gaps; inserts are the largest share of commands.
      for (int n = 0; n < 1050; n++) begin
         if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 40));
         if (n == 525) begin
            long_hold = 1'b1;
         end
         c = cmd_type'($urandom_range(0, 9) < 4 ? CMD_INSERT :
                       ($urandom_range(0, 1) ? CMD_FIND : CMD_ERASE));
         if ($urandom_range(0, 49) == 0) c = CMD_NOP;
         k = pick_key();
         if (c == CMD_INSERT && key_pool.size() < 48) key_pool.push_back(k);
         send_request(c, k, $urandom);
      end
      drain_responses();
      repeat (200) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
